[rtl/mwsc_pkg.sv]
// Package for the multiword shift copy: field widths, codes and the read control record.
package mwsc_pkg;

    localparam int WORD_W      = 64;
    localparam int IDX_W       = 6;
    localparam int SHIFT_W     = 14;
    localparam int LEN_W       = 7;
    localparam int BIT_W       = 6;
    localparam int WORDK_W     = 7;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int SHIFT_LIMIT = 4096;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_LEN   = 2'd2;

    // Decisions taken at issue time for one item, carried beside the memory read.
    typedef struct packed {
        logic             wr;
        logic             use_a;
        logic             use_b;
        logic             left;
        logic [BIT_W-1:0] b;
    } t_ctl;

endpackage

[rtl/mwsc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module mwsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/multiword_shift_copy.sv]
// Multiword bit-shift copy: source word store and shifted destination word reads.
//
//  channel   | direction | handshake                     | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: word_index, data_word; tuser: opcode
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: result_word; tuser: written
//  cfg       | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; each accepted item passes through
// the registered read of the two store copies and then the output register;
// each copy supplies one of the two adjacent source words that a read combines.
// Reset clears the handshake state and the configuration; the store itself is not cleared.
// A stalled output holds the items in flight in place and stops the input once the read stage is full.
// Configuration writes are taken in every cycle.
module multiword_shift_copy #(
    parameter int MAX_WORDS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [mwsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // word_index[5:0], data_word[69:6]
    input  logic                                 s_axis_tuser,  // opcode[0]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [mwsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // result_word[63:0]
    output logic                                 m_axis_tuser,  // written[0]
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mwsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwsc_pkg::SHIFT_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(MAX_WORDS);
    localparam int LW = $clog2(MAX_WORDS + 1);
    localparam int CW = ((LW > mwsc_pkg::WORDK_W) ? LW : mwsc_pkg::WORDK_W) + 1;
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WORDS);
    localparam int WW = mwsc_pkg::WORD_W;

    // Configuration, kept in decoded form.
    logic [LW-1:0]                  r_sl;
    logic [LW-1:0]                  r_dl;
    logic                           r_neg;
    logic                           r_zero;
    logic                           r_sat;
    logic [mwsc_pkg::WORDK_W-1:0]   r_k;
    logic [mwsc_pkg::BIT_W-1:0]     r_b;

    logic [CW-1:0]                  cfg_len_c;
    logic [CW-1:0]                  cfg_len_clamp;
    logic [mwsc_pkg::SHIFT_W-1:0]   cfg_mag;

    // Pipeline.
    logic                           r_s1_vld;
    mwsc_pkg::t_ctl                 r_s1_ctl;
    mwsc_pkg::t_ctl                 n_s1_ctl;
    logic                           r_out_vld;
    logic [WW-1:0]                  r_out_data;
    logic [WW-1:0]                  n_out_data;
    logic                           r_out_wr;

    logic                           s1_adv;
    logic                           accept;
    logic                           ram_we;

    logic [mwsc_pkg::IDX_W-1:0]     in_idx;
    logic [WW-1:0]                  in_word;
    mwsc_pkg::t_opcode              in_op;

    logic [CW-1:0] idx_c, k_c, sl_c, dl_c;
    logic [CW-1:0] n_zero, room, n_left, j_left, avail, n_right, j_right;
    logic [CW-1:0] addr_a, addr_b;

    logic [WW-1:0] rd_a;
    logic [WW-1:0] rd_b;
    logic [6:0]    comp_sh;

    assign in_idx  = s_axis_tdata[mwsc_pkg::IDX_W-1:0];
    assign in_word = s_axis_tdata[mwsc_pkg::IDX_W +: WW];
    assign in_op   = mwsc_pkg::t_opcode'(s_axis_tuser);

    // Configuration decode.
    assign o_cfg_ready   = 1'b1;
    assign cfg_len_c     = CW'(i_cfg_data[mwsc_pkg::LEN_W-1:0]);
    assign cfg_len_clamp = (cfg_len_c > MAXW_C) ? MAXW_C : cfg_len_c;
    assign cfg_mag       = i_cfg_data[mwsc_pkg::SHIFT_W-1]
                           ? (mwsc_pkg::SHIFT_W'(0) - i_cfg_data) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sl   <= '0;
            r_dl   <= '0;
            r_neg  <= 1'b0;
            r_zero <= 1'b1;
            r_sat  <= 1'b0;
            r_k    <= '0;
            r_b    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mwsc_pkg::CFG_SHIFT_BITS: begin
                    r_neg  <= i_cfg_data[mwsc_pkg::SHIFT_W-1];
                    r_zero <= (cfg_mag == '0);
                    r_sat  <= (cfg_mag > mwsc_pkg::SHIFT_W'(mwsc_pkg::SHIFT_LIMIT));
                    r_k    <= cfg_mag[mwsc_pkg::BIT_W +: mwsc_pkg::WORDK_W];
                    r_b    <= cfg_mag[mwsc_pkg::BIT_W-1:0];
                end
                mwsc_pkg::CFG_SOURCE_LEN: r_sl <= cfg_len_clamp[LW-1:0];
                mwsc_pkg::CFG_DEST_LEN:   r_dl <= cfg_len_clamp[LW-1:0];
                default: ;
            endcase
        end
    end

    // Issue: decide per read which source words are needed and where they sit.
    assign idx_c   = CW'(in_idx);
    assign k_c     = CW'(r_k);
    assign sl_c    = CW'(r_sl);
    assign dl_c    = CW'(r_dl);
    assign n_zero  = (sl_c < dl_c) ? sl_c : dl_c;
    assign room    = dl_c - k_c;
    assign n_left  = (sl_c < room) ? sl_c : room;
    assign j_left  = idx_c - k_c;
    assign avail   = sl_c - k_c;
    assign n_right = (avail < dl_c) ? avail : dl_c;
    assign j_right = idx_c + k_c;

    always_comb begin
        n_s1_ctl      = '0;
        n_s1_ctl.left = !r_neg;
        n_s1_ctl.b    = r_b;
        addr_a        = idx_c;
        addr_b        = idx_c;
        if (in_op == mwsc_pkg::OP_READ && idx_c < dl_c) begin
            priority if (r_zero) begin
                n_s1_ctl.wr    = 1'b1;
                n_s1_ctl.use_a = (idx_c < n_zero);
            end else if (!r_neg) begin
                // Left shift: words under the shift, or all words once it covers dest, are zeroed.
                priority if (r_sat || k_c >= dl_c || idx_c < k_c) begin
                    n_s1_ctl.wr = 1'b1;
                end else if (j_left < n_left) begin
                    n_s1_ctl.wr    = 1'b1;
                    n_s1_ctl.use_a = 1'b1;
                    n_s1_ctl.use_b = (r_b != '0) && (j_left != '0);
                    addr_a         = j_left;
                    addr_b         = j_left - CW'(1);
                end else begin
                    n_s1_ctl.wr = 1'b0;
                end
            end else if (!r_sat && k_c < sl_c) begin
                // Right shift: the last written word takes no bits from above.
                if (idx_c < n_right) begin
                    n_s1_ctl.wr    = 1'b1;
                    n_s1_ctl.use_a = 1'b1;
                    n_s1_ctl.use_b = (r_b != '0) && ((idx_c + CW'(1)) < n_right);
                    addr_a         = j_right;
                    addr_b         = j_right + CW'(1);
                end
            end else begin
                n_s1_ctl.wr = 1'b0;
            end
        end
    end

    assign s1_adv        = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ram_we        = accept && (in_op == mwsc_pkg::OP_LOAD) && (idx_c < MAXW_C);

    // Both copies take every load, so each read port can fetch one of the two neighbors.
    mwsc_ram #(.WIDTH(WW), .DEPTH(MAX_WORDS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_c[AW-1:0]),
        .i_wdata (in_word),
        .i_re    (accept),
        .i_raddr (addr_a[AW-1:0]),
        .o_rdata (rd_a)
    );

    mwsc_ram #(.WIDTH(WW), .DEPTH(MAX_WORDS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_c[AW-1:0]),
        .i_wdata (in_word),
        .i_re    (accept),
        .i_raddr (addr_b[AW-1:0]),
        .o_rdata (rd_b)
    );

    // Combine the two fetched words.
    assign comp_sh = 7'(WW) - 7'(r_s1_ctl.b);

    always_comb begin
        n_out_data = '0;
        if (r_s1_ctl.use_a) begin
            if (r_s1_ctl.left) begin
                n_out_data = rd_a << r_s1_ctl.b;
                if (r_s1_ctl.use_b) begin
                    n_out_data = n_out_data | (rd_b >> comp_sh);
                end
            end else begin
                n_out_data = rd_a >> r_s1_ctl.b;
                if (r_s1_ctl.use_b) begin
                    n_out_data = n_out_data | (rd_b << comp_sh);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_vld <= s_axis_tvalid;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= n_s1_ctl;
        end
        if (s1_adv && r_s1_vld) begin
            r_out_data <= n_out_data;
            r_out_wr   <= r_s1_ctl.wr;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_wr;

`ifndef SYNTH
    a_neighbor_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s1_ctl.use_b |-> r_s1_ctl.use_a)
        else $error("neighbor word used without main word");

    a_unwritten_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !r_s1_ctl.wr |-> !r_s1_ctl.use_a)
        else $error("source data fetched for an unwritten word");

    a_zero_when_unwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero result for an unwritten word");

    // Only the words that the item combines are held to be stable.
    a_read_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> (!r_s1_ctl.use_a || $stable(rd_a))
                                && (!r_s1_ctl.use_b || $stable(rd_b)))
        else $error("memory read data changed while the item was stalled");
`endif

endmodule

[sim/multiword_shift_copy_tb.sv]
// Self-checking testbench for the multiword shift copy with its own word predictor.
`timescale 1ns / 100ps

module multiword_shift_copy_tb;

    localparam int STORE_WORDS = 64;
    localparam int ITEM_GOAL   = 2000;
    // Index 3 has no register behind it; writes to it must be ignored.
    localparam logic [mwsc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        mwsc_pkg::t_opcode           op;
        logic [mwsc_pkg::IDX_W-1:0]  idx;
        logic [mwsc_pkg::WORD_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic [mwsc_pkg::WORD_W-1:0] word;
        logic                        wr;
    } t_copy_out;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [mwsc_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;  // word_index[5:0], data_word[69:6]
    logic                               s_axis_tuser = 1'b0;  // opcode[0]
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [mwsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;  // result_word[63:0]
    logic                               m_axis_tuser;  // written[0]
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [mwsc_pkg::CFG_IDX_W-1:0]     i_cfg_index = mwsc_pkg::CFG_SHIFT_BITS;
    logic [mwsc_pkg::SHIFT_W-1:0]       i_cfg_data = '0;

    // Predictor state: source words and the register settings.
    logic [mwsc_pkg::WORD_W-1:0]        src_words [STORE_WORDS];
    logic signed [mwsc_pkg::SHIFT_W-1:0] shift_cfg = '0;
    logic [mwsc_pkg::LEN_W-1:0]         src_len_cfg = '0;
    logic [mwsc_pkg::LEN_W-1:0]         dst_len_cfg = '0;

    t_item                    pending_items[$];
    t_copy_out                expected_words[$];
    logic [STORE_WORDS-1:0]   loaded_mask = '0;
    int                       queued_items = 0;
    int                       error_count = 0;
    int                       in_idle_pct = 0;
    int                       out_stall_pct = 0;
    int                       gap_left = 0;
    int                       stall_left = 0;

    multiword_shift_copy #(
        .MAX_WORDS(STORE_WORDS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Destination word idx of the shifted copy; used marks the source words it reads.
    function automatic t_copy_out shifted_word(input logic [mwsc_pkg::IDX_W-1:0] idx,
                                               output logic [STORE_WORDS-1:0] used);
        int sl, dl, sh, mag, k, b, n, j, i;
        logic left, sat;
        t_copy_out r;
        r = '0;
        used = '0;
        i = idx;
        sl = (src_len_cfg > STORE_WORDS) ? STORE_WORDS : src_len_cfg;
        dl = (dst_len_cfg > STORE_WORDS) ? STORE_WORDS : dst_len_cfg;
        sh = shift_cfg;
        left = sh > 0;
        mag = (sh < 0) ? -sh : sh;
        sat = mag > mwsc_pkg::SHIFT_LIMIT;
        k = mag >> 6;
        b = mag & 63;
        if (i < dl) begin
            if (mag == 0) begin
                n = (sl < dl) ? sl : dl;
                r.wr = 1'b1;
                if (i < n) begin
                    r.word = src_words[i];
                    used[i] = 1'b1;
                end
            end else if (left) begin
                if (sat || k >= dl || i < k) begin
                    r.wr = 1'b1;
                end else begin
                    n = (sl < dl - k) ? sl : dl - k;
                    j = i - k;
                    if (j < n) begin
                        r.wr = 1'b1;
                        r.word = src_words[j] << b;
                        used[j] = 1'b1;
                        if (b != 0 && j > 0) begin
                            r.word |= src_words[j-1] >> (64 - b);
                            used[j-1] = 1'b1;
                        end
                    end
                end
            end else if (!sat && k < sl) begin
                n = (sl - k < dl) ? sl - k : dl;
                if (i < n) begin
                    j = i + k;
                    r.wr = 1'b1;
                    r.word = src_words[j] >> b;
                    used[j] = 1'b1;
                    // The last written word takes nothing from above.
                    if (b != 0 && i + 1 < n) begin
                        r.word |= src_words[j+1] << (64 - b);
                        used[j+1] = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int idle_len(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [mwsc_pkg::WORD_W-1:0] rand_word();
        logic [mwsc_pkg::WORD_W-1:0] one;
        one = 64'd1 << $urandom_range(63);
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            2: return one;
            3: return ~one;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    task automatic take_item(input logic op, input logic [mwsc_pkg::IN_TDATA_W-1:0] td);
        logic [mwsc_pkg::IDX_W-1:0] idx;
        logic [STORE_WORDS-1:0] used;
        t_copy_out r;
        idx = td[mwsc_pkg::IDX_W-1:0];
        r = '0;
        if (mwsc_pkg::t_opcode'(op) == mwsc_pkg::OP_LOAD)
            src_words[idx] = td[mwsc_pkg::IDX_W +: mwsc_pkg::WORD_W];
        else r = shifted_word(idx, used);
        expected_words.push_back(r);
    endtask

    // Input side: present queued items with random gaps and predict each accepted one.
    always @(posedge i_clk) begin : feed
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) take_item(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_axis_tdata <= {2'b00, it.data, it.idx};
                    s_axis_tuser <= it.op;
                    s_axis_tvalid <= 1'b1;
                    gap_left = idle_len(in_idle_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = idle_len(out_stall_pct);
            m_axis_tready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin : check
        t_copy_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result word=%h written=%b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tuser !== want.wr)
                    report_mismatch($sformatf(
                        "mismatch: expected word=%h written=%b, got word=%h written=%b",
                        want.word, want.wr, m_axis_tdata, m_axis_tuser));
            end
        end
    end

    task automatic push_load(input logic [mwsc_pkg::IDX_W-1:0] idx,
                             input logic [mwsc_pkg::WORD_W-1:0] data);
        t_item it;
        it.op = mwsc_pkg::OP_LOAD;
        it.idx = idx;
        it.data = data;
        pending_items.push_back(it);
        loaded_mask[idx] = 1'b1;
        queued_items++;
    endtask

    // A read is preceded by loads of any source word it needs that was never loaded.
    task automatic push_read(input logic [mwsc_pkg::IDX_W-1:0] idx);
        t_item it;
        t_copy_out dep_out;
        logic [STORE_WORDS-1:0] used;
        dep_out = shifted_word(idx, used);
        for (int w = 0; w < STORE_WORDS; w++)
            if (used[w] && !loaded_mask[w]) push_load(mwsc_pkg::IDX_W'(w), rand_word());
        it.op = mwsc_pkg::OP_READ;
        it.idx = idx;
        it.data = rand_word();
        pending_items.push_back(it);
        queued_items++;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || expected_words.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mwsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mwsc_pkg::SHIFT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            mwsc_pkg::CFG_SHIFT_BITS: shift_cfg = data;
            mwsc_pkg::CFG_SOURCE_LEN: src_len_cfg = data[mwsc_pkg::LEN_W-1:0];
            mwsc_pkg::CFG_DEST_LEN:   dst_len_cfg = data[mwsc_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Length registers only use the low bits; the upper bits carry junk.
    task automatic reconfigure(input int shift, input int sl, input int dl);
        settle();
        write_reg(mwsc_pkg::CFG_SHIFT_BITS, mwsc_pkg::SHIFT_W'(shift));
        write_reg(mwsc_pkg::CFG_SOURCE_LEN, {7'($urandom), mwsc_pkg::LEN_W'(sl)});
        write_reg(mwsc_pkg::CFG_DEST_LEN, {7'($urandom), mwsc_pkg::LEN_W'(dl)});
        if ($urandom_range(3) == 0) write_reg(CFG_SPARE, mwsc_pkg::SHIFT_W'($urandom));
    endtask

    initial begin
        int shift, sl, dl, dlc, n;
        logic [mwsc_pkg::IDX_W-1:0] idx;
        for (int w = 0; w < STORE_WORDS; w++) src_words[w] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: plain copy, zero fill, small and word-sized shifts, saturation.
        reconfigure(0, 64, 64);
        push_load(0, '0);
        push_load(63, '1);
        push_read(0);
        push_read(63);
        reconfigure(0, 3, 5);
        push_read(2);
        push_read(4);
        reconfigure(1, 64, 64);
        push_read(0);
        push_read(63);
        reconfigure(64 * 2 + 5, 10, 8);
        push_read(1);
        push_read(2);
        push_read(7);
        reconfigure(-1, 64, 64);
        push_read(0);
        push_read(63);
        reconfigure(-(64 * 3 + 63), 10, 20);
        push_read(6);
        push_read(7);
        reconfigure(4096, 100, 127);
        push_read(63);
        reconfigure(-4096, 64, 64);
        push_read(0);
        reconfigure(8191, 64, 64);
        push_read(10);
        reconfigure(-8192, 64, 64);
        push_read(10);
        reconfigure(0, 0, 0);
        push_read(0);

        while (queued_items < ITEM_GOAL) begin
            case ($urandom_range(9))
                0: shift = 0;
                1, 2: shift = $urandom_range(127, 1);
                3, 4: shift = $urandom_range(4096, 1);
                5: shift = 64 * $urandom_range(64);
                6: shift = $urandom_range(4097, 4096);
                7: shift = $urandom_range(8191);
                default: shift = $urandom_range(63, 1);
            endcase
            if ($urandom_range(1) == 0) shift = -shift;
            case ($urandom_range(6))
                0: sl = 0;
                1: sl = 64;
                2: sl = $urandom_range(127, 65);
                3: sl = $urandom_range(4, 1);
                default: sl = $urandom_range(64);
            endcase
            case ($urandom_range(6))
                0: dl = 0;
                1: dl = 64;
                2: dl = $urandom_range(127, 65);
                3: dl = $urandom_range(4, 1);
                default: dl = $urandom_range(64);
            endcase
            reconfigure(shift, sl, dl);
            case ($urandom_range(3))
                0: begin in_idle_pct = 0; out_stall_pct = 0; end
                1: begin in_idle_pct = 10; out_stall_pct = 30; end
                2: begin in_idle_pct = 40; out_stall_pct = 10; end
                default: begin in_idle_pct = 60; out_stall_pct = 60; end
            endcase
            dlc = (dl > STORE_WORDS) ? STORE_WORDS : dl;
            n = $urandom_range(80, 20);
            repeat (n) begin
                if ($urandom_range(3) == 0) begin
                    push_load(mwsc_pkg::IDX_W'($urandom_range(63)), rand_word());
                end else begin
                    if (dlc > 0 && $urandom_range(9) < 7)
                        idx = mwsc_pkg::IDX_W'($urandom_range(dlc - 1));
                    else if (dlc < STORE_WORDS && $urandom_range(1) == 0)
                        idx = mwsc_pkg::IDX_W'(dlc);
                    else idx = mwsc_pkg::IDX_W'($urandom_range(63));
                    push_read(idx);
                end
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
